// ===== src/emtm_pkg.sv =====
`timescale 1ns / 1ps
package emtm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Sine/cosine pipeline depth, input register to result register
  localparam int unsigned SC_LAT = 11;

  // Queue between front and back; also the credit count for the lanes and queue together
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned CNTW   = $clog2(QDEPTH + 1);

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [63:0] DEG_TO_RAD = 64'd18740330;

  // Angle reduction: offset is a multiple of 360 whose quotient by 45 is a multiple of 8
  localparam logic [31:0] RED_OFFSET = 32'd11796480;
  localparam logic [63:0] RED_MUL    = ((64'd1 << 31) + 64'd44) / 64'd45;

  // Reciprocals for the odd parts of the series divisors
  localparam int unsigned DIV_SHIFT = 34;
  localparam logic [32:0] M_3  = 33'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
  localparam logic [32:0] M_5  = 33'(((64'd1 << DIV_SHIFT) + 64'd4) / 64'd5);
  localparam logic [32:0] M_7  = 33'(((64'd1 << DIV_SHIFT) + 64'd6) / 64'd7);
  localparam logic [32:0] M_15 = 33'(((64'd1 << DIV_SHIFT) + 64'd14) / 64'd15);
  localparam logic [32:0] M_21 = 33'(((64'd1 << DIV_SHIFT) + 64'd20) / 64'd21);

  typedef enum logic [1:0] {
    COL_0 = 2'd0,
    COL_1 = 2'd1,
    COL_2 = 2'd2,
    COL_3 = 2'd3
  } emtm_col_t;

  // One queued item: sines/cosines in Q2.30 plus scale and translation
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] cx;
    logic signed [31:0] sy;
    logic signed [31:0] cy;
    logic signed [31:0] sz;
    logic signed [31:0] cz;
    logic signed [31:0] scl_x;
    logic signed [31:0] scl_y;
    logic signed [31:0] scl_z;
    logic signed [31:0] shf_x;
    logic signed [31:0] shf_y;
    logic signed [31:0] shf_z;
  } emtm_entry_t;

  // Exact floor(y / d) for odd d, y below 2^30
  function automatic logic [29:0] div_odd(input logic [29:0] y, input logic [32:0] m);
    logic [63:0] p;
    p = 64'(y) * 64'(m);
    return 30'(p >> DIV_SHIFT);
  endfunction

  // Unsigned Q2.30 product, truncated
  function automatic logic [29:0] mul_u30(input logic [29:0] a, input logic [30:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 30'(p >> 30);
  endfunction

  // Signed Q2.30 product, rounded half away from zero
  function automatic logic signed [32:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] p;
    logic [33:0] r;
    logic signed [32:0] rs;
    ua = a[31] ? 32'(-a) : 32'(a);
    ub = b[31] ? 32'(-b) : 32'(b);
    p  = 64'(ua) * 64'(ub);
    r  = 34'((p + 64'd536870912) >> 30);
    rs = $signed(r[32:0]);
    return (a[31] ^ b[31]) ? -rs : rs;
  endfunction

  // Rotation term times scale, rounded half away from zero, saturated to 32 bits
  function automatic logic [31:0] scale_sat(input logic signed [32:0] r,
                                            input logic signed [31:0] s);
    logic [32:0] ur;
    logic [31:0] us;
    logic [65:0] p;
    logic [35:0] m;
    ur = r[32] ? 33'(-r) : 33'(r);
    us = s[31] ? 32'(-s) : 32'(s);
    p  = 66'(ur) * 66'(us);
    m  = 36'((p + 66'd536870912) >> 30);
    if (r[32] ^ s[31]) begin
      if (m > 36'h0_8000_0000) return 32'h8000_0000;
      else return ~m[31:0] + 32'd1;
    end else begin
      if (m > 36'h0_7FFF_FFFF) return 32'h7FFF_FFFF;
      else return m[31:0];
    end
  endfunction

endpackage

// ===== src/emtm_sincos.sv =====
`timescale 1ns / 1ps
module emtm_sincos import emtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] angle,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  localparam int unsigned AW = FRAC_BITS + 6;
  localparam logic [AW-1:0] EIGHTH = AW'(45 << FRAC_BITS);

  logic [19:0]          s0_q;
  logic [24:0]          s0_u;
  logic [FRAC_BITS-1:0] s0_lo;
  logic [AW-1:0]        s1_rem;
  logic [2:0]           s1_oct;
  logic [29:0]          s2_x;
  logic [2:0]           s2_oct;
  logic [29:0]          s3_x, s3_x2;
  logic [2:0]           s3_oct;
  logic [30:0]          s4_p, s4_c;
  logic [29:0]          s4_x, s4_x2;
  logic [2:0]           s4_oct;
  logic [29:0]          s5_mp, s5_mc, s5_x, s5_x2;
  logic [2:0]           s5_oct;
  logic [30:0]          s6_p, s6_c;
  logic [29:0]          s6_x, s6_x2;
  logic [2:0]           s6_oct;
  logic [29:0]          s7_mp, s7_mc, s7_x, s7_x2;
  logic [2:0]           s7_oct;
  logic [30:0]          s8_p, s8_c;
  logic [29:0]          s8_x, s8_x2;
  logic [2:0]           s8_oct;
  logic [29:0]          s9_s, s9_mc;
  logic [2:0]           s9_oct;

  // Floor quotient by 45 degrees via offset and reciprocal
  logic signed [31:0] v_w;
  logic [31:0]        u32_w;
  logic [63:0]        qp_w;
  assign v_w   = angle >>> FRAC_BITS;
  assign u32_w = 32'(v_w) + RED_OFFSET;
  assign qp_w  = 64'(u32_w[24:0]) * RED_MUL;

  // Remainder within the octant, mirrored in odd octants
  logic [24:0]   qm_w;
  logic [5:0]    urem_w;
  logic [AW-1:0] rem_w;
  assign qm_w   = 25'({5'd0, s0_q} * 25'd45);
  assign urem_w = 6'(s0_u - qm_w);
  assign rem_w  = {urem_w, s0_lo};

  // Degrees to radians
  logic [63:0] xp_w;
  assign xp_w = 64'(s1_rem) * DEG_TO_RAD + (64'd1 << (FRAC_BITS - 1));

  logic [63:0] x2p_w;
  assign x2p_w = 64'(s2_x) * 64'(s2_x);

  logic [30:0]        c_w;
  logic signed [31:0] se_w, ce_w;
  assign c_w  = Q30_ONE - 31'(s9_mc >> 1);
  assign se_w = 32'(s9_s);
  assign ce_w = 32'(c_w);

  always_ff @(posedge clk) begin
    s0_q  <= qp_w[50:31];
    s0_u  <= u32_w[24:0];
    s0_lo <= angle[FRAC_BITS-1:0];

    s1_rem <= s0_q[0] ? EIGHTH - rem_w : rem_w;
    s1_oct <= s0_q[2:0];

    s2_x   <= 30'(xp_w >> FRAC_BITS);
    s2_oct <= s1_oct;

    s3_x   <= s2_x;
    s3_x2  <= 30'(x2p_w >> 30);
    s3_oct <= s2_oct;

    // Innermost Horner terms: x^2/42 and x^2/56
    s4_p   <= Q30_ONE - {1'b0, div_odd(s3_x2 >> 1, M_21)};
    s4_c   <= Q30_ONE - {1'b0, div_odd(s3_x2 >> 3, M_7)};
    s4_x   <= s3_x;
    s4_x2  <= s3_x2;
    s4_oct <= s3_oct;

    s5_mp  <= mul_u30(s4_x2, s4_p);
    s5_mc  <= mul_u30(s4_x2, s4_c);
    s5_x   <= s4_x;
    s5_x2  <= s4_x2;
    s5_oct <= s4_oct;

    // Divide by 20 and 30
    s6_p   <= Q30_ONE - {1'b0, div_odd(s5_mp >> 2, M_5)};
    s6_c   <= Q30_ONE - {1'b0, div_odd(s5_mc >> 1, M_15)};
    s6_x   <= s5_x;
    s6_x2  <= s5_x2;
    s6_oct <= s5_oct;

    s7_mp  <= mul_u30(s6_x2, s6_p);
    s7_mc  <= mul_u30(s6_x2, s6_c);
    s7_x   <= s6_x;
    s7_x2  <= s6_x2;
    s7_oct <= s6_oct;

    // Divide by 6 and 12
    s8_p   <= Q30_ONE - {1'b0, div_odd(s7_mp >> 1, M_3)};
    s8_c   <= Q30_ONE - {1'b0, div_odd(s7_mc >> 2, M_3)};
    s8_x   <= s7_x;
    s8_x2  <= s7_x2;
    s8_oct <= s7_oct;

    s9_s   <= mul_u30(s8_x, s8_p);
    s9_mc  <= mul_u30(s8_x2, s8_c);
    s9_oct <= s8_oct;

    // Octant sets swap and signs
    case (s9_oct)
      3'd0: begin sn <= se_w;  cs <= ce_w;  end
      3'd1: begin sn <= ce_w;  cs <= se_w;  end
      3'd2: begin sn <= ce_w;  cs <= -se_w; end
      3'd3: begin sn <= se_w;  cs <= -ce_w; end
      3'd4: begin sn <= -se_w; cs <= -ce_w; end
      3'd5: begin sn <= -ce_w; cs <= -se_w; end
      3'd6: begin sn <= -ce_w; cs <= se_w;  end
      default: begin sn <= -se_w; cs <= ce_w; end
    endcase
  end

endmodule

// ===== src/emtm_front.sv =====
`timescale 1ns / 1ps
module emtm_front import emtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic signed [31:0] angle_x_deg,
  input  logic signed [31:0] angle_y_deg,
  input  logic signed [31:0] angle_z_deg,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  input  logic               pop,
  output logic               push,
  output emtm_entry_t        push_data
);

  logic [CNTW-1:0]   issued;
  logic [CNTW-1:0]   issued_next;
  logic [SC_LAT-1:0] vld;
  logic              acc;

  logic signed [31:0] sd_sx [SC_LAT];
  logic signed [31:0] sd_sy [SC_LAT];
  logic signed [31:0] sd_sz [SC_LAT];
  logic signed [31:0] sd_tx [SC_LAT];
  logic signed [31:0] sd_ty [SC_LAT];
  logic signed [31:0] sd_tz [SC_LAT];

  logic signed [31:0] sxw, cxw, syw, cyw, szw, czw;

  // Credits cover the pipeline plus the queue, so nothing in flight can overflow
  assign src_stall = (issued == CNTW'(QDEPTH));
  assign acc       = src_valid && !src_stall;

  always_comb begin
    issued_next = issued;
    if (acc && !pop) issued_next = issued + CNTW'(1);
    else if (!acc && pop) issued_next = issued - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= '0;
      vld    <= '0;
    end else begin
      issued <= issued_next;
      vld    <= {vld[SC_LAT-2:0], acc};
    end
  end

  // Scale and translation ride alongside the sine/cosine lanes
  always_ff @(posedge clk) begin
    sd_sx[0] <= scale_x;
    sd_sy[0] <= scale_y;
    sd_sz[0] <= scale_z;
    sd_tx[0] <= shift_x;
    sd_ty[0] <= shift_y;
    sd_tz[0] <= shift_z;
    for (int i = 1; i < SC_LAT; i++) begin
      sd_sx[i] <= sd_sx[i-1];
      sd_sy[i] <= sd_sy[i-1];
      sd_sz[i] <= sd_sz[i-1];
      sd_tx[i] <= sd_tx[i-1];
      sd_ty[i] <= sd_ty[i-1];
      sd_tz[i] <= sd_tz[i-1];
    end
  end

  emtm_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk(clk), .angle(angle_x_deg), .sn(sxw), .cs(cxw)
  );
  emtm_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk(clk), .angle(angle_y_deg), .sn(syw), .cs(cyw)
  );
  emtm_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk(clk), .angle(angle_z_deg), .sn(szw), .cs(czw)
  );

  assign push = vld[SC_LAT-1];

  always_comb begin
    push_data.sx    = sxw;
    push_data.cx    = cxw;
    push_data.sy    = syw;
    push_data.cy    = cyw;
    push_data.sz    = szw;
    push_data.cz    = czw;
    push_data.scl_x = sd_sx[SC_LAT-1];
    push_data.scl_y = sd_sy[SC_LAT-1];
    push_data.scl_z = sd_sz[SC_LAT-1];
    push_data.shf_x = sd_tx[SC_LAT-1];
    push_data.shf_y = sd_ty[SC_LAT-1];
    push_data.shf_z = sd_tz[SC_LAT-1];
  end

endmodule

// ===== src/emtm_queue.sv =====
`timescale 1ns / 1ps
module emtm_queue import emtm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  emtm_entry_t push_data,
  input  logic        pop,
  output emtm_entry_t head,
  output logic        not_empty
);

  emtm_entry_t     mem [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [CNTW-1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

  // Pointers and fill level; the front's credits keep pushes within depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop) count <= count + CNTW'(1);
      else if (!push && pop) count <= count - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== src/emtm_back.sv =====
`timescale 1ns / 1ps
module emtm_back import emtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  emtm_entry_t        head,
  input  logic               not_empty,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         column_index,
  output logic signed [31:0] elem_0,
  output logic signed [31:0] elem_1,
  output logic signed [31:0] elem_2,
  output logic signed [31:0] elem_3,
  output logic               last_column
);

  localparam logic [31:0] ONE_F = 32'(1) << FRAC_BITS;

  // Stage A: first-level products
  logic               a_valid;
  logic signed [32:0] a_cycz, a_cysz, a_t1, a_cxsz, a_cxcz, a_sxcy, a_t2, a_sxsz, a_sxcz, a_cxcy;
  logic signed [31:0] a_sy, a_sz, a_cz;
  logic signed [31:0] a_scl_x, a_scl_y, a_scl_z, a_shf_x, a_shf_y, a_shf_z;

  // Stage B: rotation matrix
  logic               b_valid;
  logic signed [32:0] b_r00, b_r01, b_r02, b_r10, b_r11, b_r12, b_r20, b_r21, b_r22;
  logic signed [31:0] b_scl_x, b_scl_y, b_scl_z, b_shf_x, b_shf_y, b_shf_z;

  // Column stage: one column per cycle while the output register is free
  logic               c_valid;
  emtm_col_t          c_col;
  logic signed [32:0] c_r00, c_r01, c_r02, c_r10, c_r11, c_r12, c_r20, c_r21, c_r22;
  logic signed [31:0] c_scl_x, c_scl_y, c_scl_z, c_shf_x, c_shf_y, c_shf_z;

  logic o_free, c_fire, c_take, b_load, a_load, c_done;

  assign o_free = !res_valid || !res_stall;
  assign c_fire = c_valid && o_free;
  assign c_done = c_fire && (c_col == COL_3);
  assign c_take = b_valid && (!c_valid || c_done);
  assign b_load = a_valid && (!b_valid || c_take);
  assign a_load = not_empty && (!a_valid || b_load);
  assign pop    = a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      c_col     <= COL_0;
      res_valid <= 1'b0;
    end else begin
      if (!a_valid || b_load) a_valid <= not_empty;
      if (!b_valid || c_take) b_valid <= a_valid;
      if (c_take) begin
        c_valid <= 1'b1;
        c_col   <= COL_0;
      end else if (c_fire) begin
        if (c_col == COL_3) c_valid <= 1'b0;
        c_col <= emtm_col_t'(c_col + 2'd1);
      end
      if (o_free) res_valid <= c_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_cycz  <= mul_q30(head.cy, head.cz);
      a_cysz  <= mul_q30(head.cy, head.sz);
      a_t1    <= mul_q30(head.sx, head.sy);
      a_cxsz  <= mul_q30(head.cx, head.sz);
      a_cxcz  <= mul_q30(head.cx, head.cz);
      a_sxcy  <= mul_q30(head.sx, head.cy);
      a_t2    <= mul_q30(head.cx, head.sy);
      a_sxsz  <= mul_q30(head.sx, head.sz);
      a_sxcz  <= mul_q30(head.sx, head.cz);
      a_cxcy  <= mul_q30(head.cx, head.cy);
      a_sy    <= head.sy;
      a_sz    <= head.sz;
      a_cz    <= head.cz;
      a_scl_x <= head.scl_x;
      a_scl_y <= head.scl_y;
      a_scl_z <= head.scl_z;
      a_shf_x <= head.shf_x;
      a_shf_y <= head.shf_y;
      a_shf_z <= head.shf_z;
    end
    if (b_load) begin
      b_r00   <= a_cycz;
      b_r01   <= -a_cysz;
      b_r02   <= 33'(a_sy);
      b_r10   <= mul_q30(a_t1[31:0], a_cz) + a_cxsz;
      b_r11   <= a_cxcz - mul_q30(a_t1[31:0], a_sz);
      b_r12   <= -a_sxcy;
      b_r20   <= a_sxsz - mul_q30(a_t2[31:0], a_cz);
      b_r21   <= mul_q30(a_t2[31:0], a_sz) + a_sxcz;
      b_r22   <= a_cxcy;
      b_scl_x <= a_scl_x;
      b_scl_y <= a_scl_y;
      b_scl_z <= a_scl_z;
      b_shf_x <= a_shf_x;
      b_shf_y <= a_shf_y;
      b_shf_z <= a_shf_z;
    end
    if (c_take) begin
      c_r00   <= b_r00;
      c_r01   <= b_r01;
      c_r02   <= b_r02;
      c_r10   <= b_r10;
      c_r11   <= b_r11;
      c_r12   <= b_r12;
      c_r20   <= b_r20;
      c_r21   <= b_r21;
      c_r22   <= b_r22;
      c_scl_x <= b_scl_x;
      c_scl_y <= b_scl_y;
      c_scl_z <= b_scl_z;
      c_shf_x <= b_shf_x;
      c_shf_y <= b_shf_y;
      c_shf_z <= b_shf_z;
    end
  end

  // Pick the current column and its scale
  logic signed [32:0] m0, m1, m2;
  logic signed [31:0] msc;
  always_comb begin
    case (c_col)
      COL_0: begin m0 = c_r00; m1 = c_r10; m2 = c_r20; msc = c_scl_x; end
      COL_1: begin m0 = c_r01; m1 = c_r11; m2 = c_r21; msc = c_scl_y; end
      COL_2: begin m0 = c_r02; m1 = c_r12; m2 = c_r22; msc = c_scl_z; end
      default: begin m0 = c_r00; m1 = c_r10; m2 = c_r20; msc = c_scl_x; end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (c_fire) begin
      column_index <= c_col;
      if (c_col == COL_3) begin
        elem_0      <= c_shf_x;
        elem_1      <= c_shf_y;
        elem_2      <= c_shf_z;
        elem_3      <= ONE_F;
        last_column <= 1'b1;
      end else begin
        elem_0      <= scale_sat(m0, msc);
        elem_1      <= scale_sat(m1, msc);
        elem_2      <= scale_sat(m2, msc);
        elem_3      <= '0;
        last_column <= 1'b0;
      end
    end
  end

endmodule

// ===== src/euler_trs_model_matrix.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// src       in         src_valid/src_stall   angle_{x,y,z}_deg, scale_{x,y,z}, shift_{x,y,z}
// res       out        res_valid/res_stall   column_index, elem_0..elem_3, last_column
//
// Each item yields four result items, columns 0..3, one per cycle while res_stall is low;
// the single column stage takes a new item only as it sends column 3 of the last one.
// Column 0 goes through the 11-stage sine/cosine lanes, queue, two product stages, column
// stage and output register.
// rst is synchronous; it clears the credit count, queue pointers and stage valids.
// 8 credits cover the sine/cosine lanes and queue, with up to three more items in the back
// stages; src_stall rises when all credits are out, and
// res_stall holds the output register and backs up the queue.
module euler_trs_model_matrix import emtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic signed [31:0] angle_x_deg,
  input  logic signed [31:0] angle_y_deg,
  input  logic signed [31:0] angle_z_deg,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         column_index,
  output logic signed [31:0] elem_0,
  output logic signed [31:0] elem_1,
  output logic signed [31:0] elem_2,
  output logic signed [31:0] elem_3,
  output logic               last_column
);

  logic        push, pop, not_empty;
  emtm_entry_t push_data, head;

  emtm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .angle_x_deg(angle_x_deg), .angle_y_deg(angle_y_deg), .angle_z_deg(angle_z_deg),
    .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
    .shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z),
    .pop(pop), .push(push), .push_data(push_data)
  );

  emtm_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data),
    .pop(pop), .head(head), .not_empty(not_empty)
  );

  emtm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .head(head), .not_empty(not_empty), .pop(pop),
    .res_valid(res_valid), .res_stall(res_stall),
    .column_index(column_index),
    .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
    .last_column(last_column)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench import emtm_pkg::*; ();

  typedef struct packed {
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] kx, ky, kz;
    logic signed [31:0] tx, ty, tz;
  } xform_t;

  typedef struct packed {
    logic [1:0]         col;
    logic signed [31:0] e0, e1, e2, e3;
    logic               last;
  } column_t;

  localparam int FB = 16;

  logic clk = 0;
  logic rst = 1;
  logic src_valid = 0;
  logic src_stall;
  logic signed [31:0] angle_x_deg = 0, angle_y_deg = 0, angle_z_deg = 0;
  logic signed [31:0] scale_x = 0, scale_y = 0, scale_z = 0;
  logic signed [31:0] shift_x = 0, shift_y = 0, shift_z = 0;
  logic res_valid;
  logic res_stall = 0;
  logic [1:0] column_index;
  logic signed [31:0] elem_0, elem_1, elem_2, elem_3;
  logic last_column;

  euler_trs_model_matrix i_dut (.*);

  xform_t  pending_xforms[$];
  column_t expected_columns[$];
  int      mismatches = 0;
  int      columns_seen = 0;
  int      xforms_sent = 0;
  int      src_idle_pct = 0;
  int      res_stall_pct = 0;
  bit      hold_off = 0;
  bit      hold_req = 0;
  bit      hold_done = 0;

  initial forever #5 clk = ~clk;

  // signed product shifted right, rounded half away from zero
  function automatic longint rnd_mul(longint a, longint b, int sh);
    logic [127:0] p;
    longint ua, ub, r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = 128'(ua) * 128'(ub) + (128'd1 << (sh - 1));
    r = longint'(p >> sh);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // octant-folded Taylor sine/cosine in Q2.30
  task automatic deg_sin_cos(input logic signed [31:0] a, output longint sn, output longint cs);
    longint full, eighth, r, oct, rem;
    longint unsigned x, x2, p, q, s, c, one;
    full = 360 << FB;
    eighth = 45 << FB;
    one = 64'd1 << 30;
    r = longint'(a) % full;
    if (r < 0) r += full;
    oct = r / eighth;
    rem = r - oct * eighth;
    if (oct & 1) rem = eighth - rem;
    x = (longint'(rem) * 18740330 + (64'd1 << (FB - 1))) >> FB;
    x2 = (x * x) >> 30;
    p = one - x2 / 42;
    p = one - ((x2 * p) >> 30) / 20;
    p = one - ((x2 * p) >> 30) / 6;
    s = (x * p) >> 30;
    q = one - x2 / 56;
    q = one - ((x2 * q) >> 30) / 30;
    q = one - ((x2 * q) >> 30) / 12;
    c = one - ((x2 * q) >> 30) / 2;
    case (oct & 7)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = s;  end
      2: begin sn = c;  cs = -c + c - s; end
      3: begin sn = s;  cs = -c; end
      4: begin sn = -s; cs = -c; end
      5: begin sn = -c; cs = -s; end
      6: begin sn = -c; cs = s;  end
      default: begin sn = -s; cs = c; end
    endcase
  endtask

  function automatic logic [31:0] scale_clip(longint rot, logic signed [31:0] k);
    longint v;
    v = rnd_mul(rot, longint'(k), 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // model matrix columns for one transform
  task automatic predict_matrix(input xform_t t);
    longint sx, cx, sy, cy, sz, cz, u;
    longint m[3][3];
    logic signed [31:0] k[3];
    column_t c;
    deg_sin_cos(t.ax, sx, cx);
    deg_sin_cos(t.ay, sy, cy);
    deg_sin_cos(t.az, sz, cz);
    k = '{t.kx, t.ky, t.kz};
    m[0][0] = rnd_mul(cy, cz, 30);
    m[0][1] = -rnd_mul(cy, sz, 30);
    m[0][2] = sy;
    u = rnd_mul(sx, sy, 30);
    m[1][0] = rnd_mul(u, cz, 30) + rnd_mul(cx, sz, 30);
    m[1][1] = rnd_mul(cx, cz, 30) - rnd_mul(u, sz, 30);
    m[1][2] = -rnd_mul(sx, cy, 30);
    u = rnd_mul(cx, sy, 30);
    m[2][0] = rnd_mul(sx, sz, 30) - rnd_mul(u, cz, 30);
    m[2][1] = rnd_mul(u, sz, 30) + rnd_mul(sx, cz, 30);
    m[2][2] = rnd_mul(cx, cy, 30);
    for (int j = 0; j < 3; j++) begin
      c.col = emtm_col_t'(j);
      c.e0 = scale_clip(m[0][j], k[j]);
      c.e1 = scale_clip(m[1][j], k[j]);
      c.e2 = scale_clip(m[2][j], k[j]);
      c.e3 = 0;
      c.last = 0;
      expected_columns.push_back(c);
    end
    c.col = COL_3;
    c.e0 = t.tx;
    c.e1 = t.ty;
    c.e2 = t.tz;
    c.e3 = 32'sd1 <<< FB;
    c.last = 1;
    expected_columns.push_back(c);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("MISMATCH col %0d %s: got %h want %h", column_index, what, got, want);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 720 << FB) - (360 << FB);
      3: return {$urandom_range(0, 3) * 45 + (($urandom_range(0, 1)) ? 90 : 0), 16'h0};
      4: return $urandom_range(0, 8 << FB) - (4 << FB);
      default: return $urandom;
    endcase
  endfunction

  function automatic xform_t make_xform(logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [31:0] c, logic signed [31:0] k,
                                        logic signed [31:0] s);
    xform_t t;
    t = '{a, b, c, k, k, k, s, -s, s ^ 32'h5555_5555};
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 0;
    end else if (!src_valid || !src_stall) begin
      if (src_valid) xforms_sent++;
      if (pending_xforms.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        xform_t t;
        t = pending_xforms.pop_front();
        predict_matrix(t);
        src_valid <= 1;
        {angle_x_deg, angle_y_deg, angle_z_deg, scale_x, scale_y, scale_z,
         shift_x, shift_y, shift_z} <= t;
      end else begin
        src_valid <= 0;
      end
    end
  end

  // result stall
  always @(posedge clk) begin
    if (rst) res_stall <= 0;
    else res_stall <= hold_off || ($urandom_range(0, 99) < res_stall_pct);
  end

  // long output hold-off, timed here while the sender keeps offering items
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
    hold_done = 1;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      columns_seen++;
      if (expected_columns.size() == 0) begin
        report_mismatch("unexpected", 32'(column_index), 32'd0);
      end else begin
        column_t w;
        w = expected_columns.pop_front();
        if (column_index != w.col) report_mismatch("index", 32'(column_index), 32'(w.col));
        if (elem_0 != w.e0) report_mismatch("elem_0", elem_0, w.e0);
        if (elem_1 != w.e1) report_mismatch("elem_1", elem_1, w.e1);
        if (elem_2 != w.e2) report_mismatch("elem_2", elem_2, w.e2);
        if (elem_3 != w.e3) report_mismatch("elem_3", elem_3, w.e3);
        if (last_column != w.last) report_mismatch("last", 32'(last_column), 32'(w.last));
      end
    end
  end

  task automatic drain();
    while (pending_xforms.size() > 0 || src_valid || expected_columns.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int idle[4];
    int stall[4];
    idle = '{0, 85, 0, 34};
    stall = '{0, 0, 85, 34};
    repeat (2) @(posedge clk);
    rst <= 0;
    // extremes, octant edges, saturating scales
    pending_xforms.push_back(make_xform(0, 0, 0, 1 << FB, 0));
    pending_xforms.push_back(make_xform(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_xforms.push_back(make_xform(32'h7FFF_FFFF, 32'h8000_0000, 1,
                                       32'h8000_0000, 32'h8000_0000));
    for (int o = 0; o < 9; o++)
      pending_xforms.push_back(make_xform((o * 45) << FB, -((o * 45) << FB),
                                          ((o * 45) + 22) << FB, 2 << FB, o << FB));
    pending_xforms.push_back(make_xform(360 << FB, -(360 << FB), 720 << FB, -(1 << FB), -1));
    pending_xforms.push_back(make_xform(30 << FB, 60 << FB, 90 << FB, 32'h7FFF_FFFF, 5));
    pending_xforms.push_back(make_xform(-(30 << FB), 1, -1, 32'h8000_0000, 0));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = idle[ph];
      res_stall_pct = stall[ph];
      for (int n = 0; n < 64; n++) begin
        xform_t t;
        t = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
             rand_field(), $urandom, $urandom, $urandom};
        pending_xforms.push_back(t);
      end
      if (ph == 0) begin
        hold_req = 1;
        wait (hold_done);
      end
      drain();
    end
    repeat (40) @(posedge clk);
    $display("Covered %0d transforms, %0d columns: angle extremes, all octants,", xforms_sent,
             columns_seen);
    $display("saturating scales, idle/stall phases and a long output hold-off.");
    if (mismatches == 0 && expected_columns.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end
endmodule
